// File: hw/rtl/msk_pkg.sv
// Package for the min tracking stack: sizes, codes, state and command types.
// Shared by msk_ctrl, msk_dp and min_tracking_stack_unit; no dependencies.
`default_nettype none

package msk_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_state_t;

  // capture: latch the request and read the top entries; execute: update stack
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/msk_ctrl.sv
// Controller for the min tracking stack: two-state sequencer and result strobe.
// Depends on msk_pkg.
`default_nettype none

module msk_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  output logic                 out_valid,
  output msk_pkg::dp_cmd_t     cmd
);
  import msk_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    valid_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: cmd.capture = start;
      S_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
        valid_nxt   = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/msk_dp.sv
// Datapath for the min tracking stack: value and running-min memories, count,
// cached top minimum and result registers. Depends on msk_pkg.
`default_nettype none

module msk_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire msk_pkg::dp_cmd_t                         cmd,
  input  wire logic                                     in_mode,
  input  wire logic signed [msk_pkg::DATA_WIDTH-1:0]    in_push_value,
  output logic signed [msk_pkg::DATA_WIDTH-1:0]         out_popped_value,
  output logic signed [msk_pkg::DATA_WIDTH-1:0]         out_current_min,
  output logic                                          out_min_valid,
  output logic [1:0]                                    out_status,
  output logic [msk_pkg::CNT_W-1:0]                     out_entry_count
);
  import msk_pkg::*;

  logic signed [DATA_WIDTH-1:0] val_mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] min_mem [DEPTH];

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic signed [DATA_WIDTH-1:0] top_min_r, top_min_nxt;
  logic                         mode_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  logic signed [DATA_WIDTH-1:0] rd_val_r;
  logic signed [DATA_WIDTH-1:0] rd_min_r;

  logic signed [DATA_WIDTH-1:0] pop_r, pop_nxt;
  logic signed [DATA_WIDTH-1:0] min_r, min_nxt;
  logic                         minv_r, minv_nxt;
  status_t                      status_r, status_nxt;
  logic [CNT_W-1:0]             cnt_out_r;

  logic [CNT_W-1:0]             cnt_m1, cnt_m2;
  logic                         full, empty, do_push;
  logic signed [DATA_WIDTH-1:0] push_min;

  assign cnt_m1 = count_r - CNT_W'(1);
  assign cnt_m2 = count_r - CNT_W'(2);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign do_push = (mode_r == MODE_PUSH) && !full;

  // an equal value keeps the existing minimum
  assign push_min = (!empty && !(val_r < top_min_r)) ? top_min_r : val_r;

  always_comb begin
    count_nxt   = count_r;
    top_min_nxt = top_min_r;
    pop_nxt     = '0;
    min_nxt     = '0;
    minv_nxt    = 1'b0;
    status_nxt  = ST_OK;
    priority if (mode_r == MODE_PUSH && full) begin
      status_nxt = ST_OVERFLOW;
      min_nxt    = top_min_r;
      minv_nxt   = 1'b1;
    end else if (mode_r == MODE_PUSH) begin
      count_nxt   = count_r + CNT_W'(1);
      top_min_nxt = push_min;
      min_nxt     = push_min;
      minv_nxt    = 1'b1;
    end else if (empty) begin
      status_nxt = ST_UNDERFLOW;
    end else begin
      count_nxt = cnt_m1;
      pop_nxt   = rd_val_r;
      if (cnt_m1 != '0) begin
        top_min_nxt = rd_min_r;
        min_nxt     = rd_min_r;
        minv_nxt    = 1'b1;
      end
    end
  end

  // reads of the top two entries happen on the transfer edge
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      val_r    <= in_push_value;
      rd_val_r <= val_mem[cnt_m1[IDX_W-1:0]];
      rd_min_r <= min_mem[cnt_m2[IDX_W-1:0]];
    end
    if (cmd.execute && do_push) begin
      val_mem[count_r[IDX_W-1:0]] <= val_r;
      min_mem[count_r[IDX_W-1:0]] <= push_min;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      top_min_r <= top_min_nxt;
      pop_r     <= pop_nxt;
      min_r     <= min_nxt;
      minv_r    <= minv_nxt;
      status_r  <= status_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  assign out_popped_value = pop_r;
  assign out_current_min  = min_r;
  assign out_min_valid    = minv_r;
  assign out_status       = status_r;
  assign out_entry_count  = cnt_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stack count beyond depth");

  a_minv_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> (out_min_valid == (out_entry_count != '0)))
    else $error("min valid flag disagrees with entry count");

  a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> (out_entry_count == count_r))
    else $error("reported count differs from stack count");

  a_no_cmd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

endmodule

`default_nettype wire

// File: hw/rtl/min_tracking_stack_unit.sv
// Top level of the min tracking stack: controller plus datapath.
// Depends on msk_pkg, msk_ctrl and msk_dp.
//
//   channel   handshake          payload
//   input     start / busy       in_mode, in_push_value
//   result    out_valid strobe   out_popped_value, out_current_min,
//                                out_min_valid, out_status, out_entry_count
//
// In an operation the transfer edge reads the top two memory entries; the
// execute state then updates the stack and registers the result and strobe.
// A new start is taken in the cycle the previous result is on the ports.
// Reset (rst_n low, synchronous) empties the stack; memory contents are kept.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module min_tracking_stack_unit (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     start,
  output logic                                          busy,
  input  wire logic                                     in_mode,
  input  wire logic signed [msk_pkg::DATA_WIDTH-1:0]    in_push_value,
  output logic                                          out_valid,
  output logic signed [msk_pkg::DATA_WIDTH-1:0]         out_popped_value,
  output logic signed [msk_pkg::DATA_WIDTH-1:0]         out_current_min,
  output logic                                          out_min_valid,
  output logic [1:0]                                    out_status,
  output logic [msk_pkg::CNT_W-1:0]                     out_entry_count
);
  import msk_pkg::*;

  dp_cmd_t cmd;

  msk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  msk_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_mode          (in_mode),
    .in_push_value    (in_push_value),
    .out_popped_value (out_popped_value),
    .out_current_min  (out_current_min),
    .out_min_valid    (out_min_valid),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

endmodule

`default_nettype wire
